### rtl/shared_pool_multi_stack_top_defines.svh
// Assertion macros used by the checker file of the multi-stack pool
`ifndef SHARED_POOL_MULTI_STACK_TOP_DEFINES_SVH
`define SHARED_POOL_MULTI_STACK_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define SPMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define SPMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/spms_pkg.sv
// Types and constants of the multi-stack shared pool
package spms_pkg;

  localparam int DEF_POOL_DEPTH = 16;
  localparam int DEF_NUM_STACKS = 3;
  localparam int DATA_W         = 32;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 48;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_TOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_EXHAUSTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_DATA = 2'd2
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] top_value;
    status_e           status;
    logic [4:0]        stack_depth;
    logic [4:0]        free_slots;
  } result_t;

endpackage

### rtl/spms_out.sv
// Output register for result items of the multi-stack pool
module spms_out (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 ld,
  input  spms_pkg::result_t                    res,
  output logic                                 room,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // top_value[31:0], status[33:32], stack_depth[38:34], free_slots[43:39], zeros
  output logic [spms_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic              valid_r;
  logic              valid_nxt;
  spms_pkg::result_t res_r;

  assign room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (ld) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0, res_r.free_slots, res_r.stack_depth, res_r.status,
                       res_r.top_value};

endmodule

### rtl/shared_pool_multi_stack_top.sv
// Several stacks sharing one pool of data slots through a free-slot stack.
// An accepted item reads the free list and the stack-slot memory as it is taken in and
// finishes in S_READ, which serves push, pop and failed or unused commands;
// a successful read top goes on to S_DATA, since the slot found in the stack-slot memory must then be
// read from the data memory. Only one item is at work at a time; the next is accepted as
// soon as the result is in the output register, and a stalled output holds the block.
// No clearing pass follows reset: a low-water mark of the free count marks the free-list
// entries never written, which read as their own index.
module shared_pool_multi_stack_top #(
  parameter int POOL_DEPTH = spms_pkg::DEF_POOL_DEPTH,
  parameter int NUM_STACKS = spms_pkg::DEF_NUM_STACKS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // command[1:0], stack_select[3:2], push_value[35:4], zeros
  input  logic [spms_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // top_value[31:0], status[33:32], stack_depth[38:34], free_slots[43:39], zeros
  output logic [spms_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int PW       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW       = $clog2(POOL_DEPTH + 1);
  localparam int SW       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SS_DEPTH = NUM_STACKS * POOL_DEPTH;
  localparam int AW       = (SS_DEPTH > 1) ? $clog2(SS_DEPTH) : 1;
  localparam int EW       = CW + 5;
  localparam int DW       = spms_pkg::DATA_W;

  spms_pkg::state_e state_r, state_nxt;

  spms_pkg::cmd_e   cmd_r;
  logic [SW-1:0]    sel_idx_r;
  logic             sel_ok_r;
  logic [DW-1:0]    val_r;

  logic [CW-1:0]    fc_r, fc_nxt;
  logic [CW-1:0]    lw_r, lw_nxt;
  logic [CW-1:0]    cnt_r [NUM_STACKS];

  logic [PW-1:0]    fl_mem [POOL_DEPTH];
  logic [PW-1:0]    fl_rd_r;
  logic [PW-1:0]    ss_mem [SS_DEPTH];
  logic [PW-1:0]    ss_rd_r;
  logic [DW-1:0]    sd_mem [POOL_DEPTH];
  logic [DW-1:0]    sd_rd_r;

  logic             in_acc;
  logic [1:0]       in_sel;
  logic [SW+1:0]    in_sel_ext;
  logic [SW-1:0]    in_sel_idx;
  logic             in_sel_ok;
  logic [CW-1:0]    in_cnt;
  logic [AW-1:0]    in_base;
  logic [AW-1:0]    ss_raddr;
  logic [CW-1:0]    in_fc_m1;
  logic [PW-1:0]    fl_raddr;
  logic             fl_re, ss_re, sd_re;

  logic [CW-1:0]    cnt_cur;
  logic [AW-1:0]    base_r_addr;
  logic [AW-1:0]    ss_waddr;
  logic [CW-1:0]    fc_m1;
  logic [PW-1:0]    new_slot;
  logic             push_ok, pop_ok, top_ok, commit;
  logic             sd_we, ss_we, fl_we;
  logic [CW-1:0]    cnt_after;
  logic [EW-1:0]    depth_ext, free_ext;

  spms_pkg::result_t res;
  logic              res_ld;
  logic              room;

  // input side decode
  assign in_tready  = (state_r == spms_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_sel     = in_tdata[3:2];
  assign in_sel_ext = (SW+2)'(in_sel);
  assign in_sel_idx = in_sel_ext[SW-1:0];
  assign in_sel_ok  = (32'(in_sel) < NUM_STACKS);
  assign in_cnt     = in_sel_ok ? cnt_r[in_sel_idx] : '0;
  assign in_base    = AW'(in_sel_idx) * AW'(POOL_DEPTH);
  assign ss_raddr   = in_base + AW'(in_cnt) - AW'(1);
  assign in_fc_m1   = fc_r - CW'(1);
  assign fl_raddr   = in_fc_m1[PW-1:0];
  assign fl_re      = in_acc && (fc_r != '0);
  assign ss_re      = in_acc && (in_cnt != '0);

  // operation decode on held item
  assign cnt_cur     = sel_ok_r ? cnt_r[sel_idx_r] : '0;
  assign base_r_addr = AW'(sel_idx_r) * AW'(POOL_DEPTH);
  assign ss_waddr    = base_r_addr + AW'(cnt_cur);
  assign fc_m1       = fc_r - CW'(1);
  assign new_slot    = (fc_r <= lw_r) ? fc_m1[PW-1:0] : fl_rd_r;
  assign push_ok     = sel_ok_r && (cmd_r == spms_pkg::CMD_PUSH) && (fc_r != '0) &&
                       (cnt_cur < CW'(POOL_DEPTH));
  assign pop_ok      = sel_ok_r && (cmd_r == spms_pkg::CMD_POP) && (cnt_cur != '0);
  assign top_ok      = sel_ok_r && (cmd_r == spms_pkg::CMD_TOP) && (cnt_cur != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spms_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = spms_pkg::S_READ;
        end
      end
      spms_pkg::S_READ: begin
        if (top_ok) begin
          state_nxt = spms_pkg::S_DATA;
        end else if (room) begin
          state_nxt = spms_pkg::S_IDLE;
        end
      end
      spms_pkg::S_DATA: begin
        if (room) begin
          state_nxt = spms_pkg::S_IDLE;
        end
      end
      default: state_nxt = spms_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    commit = 1'b0;
    sd_re  = 1'b0;
    res_ld = 1'b0;
    unique case (state_r)
      spms_pkg::S_IDLE: begin
      end
      spms_pkg::S_READ: begin
        sd_re  = top_ok;
        commit = !top_ok && room;
        res_ld = commit;
      end
      spms_pkg::S_DATA: begin
        res_ld = room;
      end
      default: begin
      end
    endcase
  end

  assign sd_we = commit && push_ok;
  assign ss_we = commit && push_ok;
  assign fl_we = commit && pop_ok && (fc_r < CW'(POOL_DEPTH));

  always_comb begin
    fc_nxt    = fc_r;
    lw_nxt    = lw_r;
    cnt_after = cnt_cur;
    if (push_ok) begin
      cnt_after = cnt_cur + CW'(1);
      fc_nxt    = fc_m1;
      if (fc_r <= lw_r) begin
        lw_nxt = fc_m1;
      end
    end else if (pop_ok) begin
      cnt_after = cnt_cur - CW'(1);
      if (fc_r < CW'(POOL_DEPTH)) begin
        fc_nxt = fc_r + CW'(1);
      end
    end
  end

  // result
  always_comb begin
    res           = '0;
    res.status    = spms_pkg::STS_OK;
    depth_ext     = EW'(cnt_cur);
    free_ext      = EW'(fc_r);
    if (state_r == spms_pkg::S_DATA) begin
      res.top_value = sd_rd_r;
    end else begin
      depth_ext = EW'(cnt_after);
      free_ext  = EW'(fc_nxt);
      if (sel_ok_r && (cmd_r == spms_pkg::CMD_PUSH) && !push_ok) begin
        res.status = spms_pkg::STS_EXHAUSTED;
      end else if (sel_ok_r && (cnt_cur == '0) &&
                   ((cmd_r == spms_pkg::CMD_POP) || (cmd_r == spms_pkg::CMD_TOP))) begin
        res.status = spms_pkg::STS_EMPTY;
      end
    end
    res.stack_depth = depth_ext[4:0];
    res.free_slots  = free_ext[4:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spms_pkg::S_IDLE;
      fc_r    <= CW'(POOL_DEPTH);
      lw_r    <= CW'(POOL_DEPTH);
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        fc_r <= fc_nxt;
        lw_r <= lw_nxt;
        if (sel_ok_r) begin
          cnt_r[sel_idx_r] <= cnt_after;
        end
      end
    end
  end

  // held item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= spms_pkg::cmd_e'(in_tdata[1:0]);
      sel_idx_r <= in_sel_idx;
      sel_ok_r  <= in_sel_ok;
      val_r     <= in_tdata[35:4];
    end
  end

  // free list memory
  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fc_r[PW-1:0]] <= ss_rd_r;
    end
    if (fl_re) begin
      fl_rd_r <= fl_mem[fl_raddr];
    end
  end

  // stack slot memory
  always_ff @(posedge clk) begin
    if (ss_we) begin
      ss_mem[ss_waddr] <= new_slot;
    end
    if (ss_re) begin
      ss_rd_r <= ss_mem[ss_raddr];
    end
  end

  // slot data memory
  always_ff @(posedge clk) begin
    if (sd_we) begin
      sd_mem[new_slot] <= val_r;
    end
    if (sd_re) begin
      sd_rd_r <= sd_mem[ss_rd_r];
    end
  end

  spms_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (res_ld),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/spms_checker.sv
// Port-level checks of the multi-stack pool and their binding to the top level
`include "shared_pool_multi_stack_top_defines.svh"

module spms_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [spms_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic                        in_acc;
  logic                        out_stall;
  logic [1:0]                  out_status;
  logic [spms_pkg::DATA_W-1:0] out_top;
  logic                        out_fail;

  assign in_acc     = in_tvalid && in_tready;
  assign out_stall  = out_tvalid && !out_tready;
  assign out_status = out_tdata[33:32];
  assign out_top    = out_tdata[31:0];
  assign out_fail   = out_tvalid && (out_status != spms_pkg::STS_OK);

  `SPMS_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "stalled item changed")
  `SPMS_ASSERT_NEXT(a_one_item, in_acc, !in_tready, "second item accepted while one is at work")
  `SPMS_ASSERT_SAME(a_status_code, out_tvalid, out_status <= spms_pkg::STS_EXHAUSTED, "bad status")
  `SPMS_ASSERT_SAME(a_fail_zero, out_fail, out_top == '0, "failed item carries a top value")

endmodule

bind shared_pool_multi_stack_top spms_checker u_spms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
